>>> design/m4inv_pkg.sv
// Shared types, constants and helper functions for the 4x4 adjugate inverter.
// No dependencies; imported by mat4_inverse_adjugate.
package m4inv_pkg;

  localparam int FRAC_BITS = 16;
  // The reciprocal quotient 2^(2F) / |det| needs 2F+1 bits.
  localparam int QW        = 2 * FRAC_BITS + 1;
  localparam int DCW       = $clog2(QW);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(QW - 1);

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

  typedef enum logic [3:0] {
    S_LOAD, S_FETCH_A, S_FETCH_B, S_MUL, S_ACC, S_FIN, S_APPLY,
    S_STORE, S_DIVCHK, S_DIV, S_SING
  } state_t;

  typedef enum logic [1:0] {PH_COF, PH_DET, PH_OUT} phase_t;

  typedef enum logic [1:0] {AM_LOAD, AM_ADD, AM_SUB} acc_mode_t;

  // One multiply of the 3x3 minor program. Operand A is always an element of
  // the 3x3 block; operand B is an element or the partial term register.
  typedef struct packed {
    logic [3:0] ia;
    logic [3:0] ib;
    logic       b_is_c;
    logic       to_acc;
    acc_mode_t  mode;
  } mop_t;

  localparam int NUM_OPS = 9;
  localparam logic [3:0] OP_LAST = 4'(NUM_OPS - 1);

  localparam mop_t OP_TABLE [NUM_OPS] = '{
    '{4'd4, 4'd8, 1'b0, 1'b0, AM_LOAD},
    '{4'd5, 4'd7, 1'b0, 1'b0, AM_SUB},
    '{4'd0, 4'd0, 1'b1, 1'b1, AM_LOAD},
    '{4'd3, 4'd8, 1'b0, 1'b0, AM_LOAD},
    '{4'd5, 4'd6, 1'b0, 1'b0, AM_SUB},
    '{4'd1, 4'd0, 1'b1, 1'b1, AM_SUB},
    '{4'd3, 4'd7, 1'b0, 1'b0, AM_LOAD},
    '{4'd4, 4'd6, 1'b0, 1'b0, AM_SUB},
    '{4'd2, 4'd0, 1'b1, 1'b1, AM_ADD}
  };

  localparam logic [1:0] T_GRP [NUM_OPS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                            2'd2, 2'd2, 2'd2};
  localparam logic [1:0] T_SLT [NUM_OPS] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                            2'd0, 2'd1, 2'd2};

  // Maps a 3x3 block position to the stored element, skipping group ra and
  // slot cb of the 4x4 matrix.
  function automatic logic [3:0] tsel(input logic [3:0] n, input logic [1:0] ra,
                                      input logic [1:0] cb);
    logic [1:0] gi;
    logic [1:0] hi;
    logic [1:0] g;
    logic [1:0] h;
    gi = T_GRP[n];
    hi = T_SLT[n];
    g  = gi + ((gi >= ra) ? 2'd1 : 2'd0);
    h  = hi + ((hi >= cb) ? 2'd1 : 2'd0);
    return {g, h};
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] sat_addsub(input logic signed [63:0] x,
                                                    input logic signed [63:0] y,
                                                    input logic sub);
    logic signed [64:0] z;
    z = sub ? ({x[63], x} - {y[63], y}) : ({x[63], x} + {y[63], y});
    if (z[64] != z[63]) begin
      return z[64] ? S64_MIN : S64_MAX;
    end
    return z[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'(S32_MAX)) begin
      return S32_MAX;
    end
    if (x < $signed({{32{1'b1}}, S32_MIN})) begin
      return S32_MIN;
    end
    return x[31:0];
  endfunction

endpackage

>>> design/mat4_inverse_adjugate.sv
// 4x4 fixed-point matrix inverse by adjugate and determinant reciprocal.
// Depends on m4inv_pkg for types, the minor program table and saturation helpers.
//
//  channel | signals                                   | direction | handshake
//  input   | elem_value                                | in        | start & !busy
//  result  | out_value, out_index, singular, last      | out       | result_valid, 1 cycle
//
// One element is taken per cycle while start is high. After the sixteenth,
// one shared 32x32 multiplier does every fixed multiply (operand fetch, four
// partial products, scale and saturate, apply): 144 for the minors with 16
// cofactor stores, 4 for the determinant and a check; then, unless singular,
// a 33-step restoring divider for the reciprocal and 16 for the outputs.
// One result comes per output multiply (one per cycle when singular).
// Synchronous reset returns to loading at element 0. The receiver cannot
// stall; busy stays high until the last result is emitted.
module mat4_inverse_adjugate (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  elem_value,
  output logic                result_valid,
  output logic signed [31:0]  out_value,
  output logic [3:0]          out_index,
  output logic                singular,
  output logic                last
);
  import m4inv_pkg::*;

  state_t state, state_next;
  phase_t phase;

  logic signed [31:0] mat [16];
  logic signed [63:0] adj [16];
  logic [3:0]         load_count;
  logic [3:0]         idx;
  logic [3:0]         opn;
  logic [1:0]         step;
  logic [DCW-1:0]     divcnt;

  logic [63:0]        ma, mb;
  logic               sa, sb;
  logic [63:0]        prod;
  logic [127:0]       macc;
  logic signed [63:0] fres;
  logic signed [63:0] c_term, acc;
  logic [63:0]        dmag;
  logic               dneg;
  logic [63:0]        rem;
  logic [QW-1:0]      quo;
  logic signed [63:0] recip;

  mop_t               cur_op;
  logic [3:0]         addr_a, addr_b;
  logic signed [63:0] src_a, src_b;
  logic [127:0]       addend;
  logic [63:0]        mlo;
  logic [63:0]        mag;
  logic [64:0]        rem_sh;
  logic               do_accept;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:    if (start && load_count == 4'd15) state_next = S_FETCH_A;
      S_FETCH_A: state_next = S_FETCH_B;
      S_FETCH_B: state_next = S_MUL;
      S_MUL:     state_next = S_ACC;
      S_ACC:     state_next = (step == 2'd3) ? S_FIN : S_MUL;
      S_FIN:     state_next = S_APPLY;
      S_APPLY: begin
        case (phase)
          PH_COF:  state_next = (opn == OP_LAST) ? S_STORE : S_FETCH_A;
          PH_DET:  state_next = (idx == 4'd3) ? S_DIVCHK : S_FETCH_A;
          default: state_next = (idx == 4'd15) ? S_LOAD : S_FETCH_A;
        endcase
      end
      S_STORE:   state_next = S_FETCH_A;
      S_DIVCHK:  state_next = (acc == 64'sd0) ? S_SING : S_DIV;
      S_DIV:     state_next = (divcnt == DIV_LAST) ? S_FETCH_A : S_DIV;
      S_SING:    state_next = (idx == 4'd15) ? S_LOAD : S_SING;
      default:   state_next = S_LOAD;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy      = (state != S_LOAD);
    do_accept = start && (state == S_LOAD);
  end

  // Operand selection and arithmetic helpers.
  always_comb begin
    cur_op = OP_TABLE[opn];
    addr_a = tsel(cur_op.ia, idx[3:2], idx[1:0]);
    addr_b = tsel(cur_op.ib, idx[3:2], idx[1:0]);
    case (phase)
      PH_COF: begin
        src_a = 64'(mat[addr_a]);
        src_b = cur_op.b_is_c ? c_term : 64'(mat[addr_b]);
      end
      PH_DET: begin
        src_a = 64'(mat[{idx[1:0], 2'b00}]);
        src_b = adj[{2'b00, idx[1:0]}];
      end
      default: begin
        src_a = adj[idx];
        src_b = recip;
      end
    endcase
    case (step)
      2'd0:    addend = {64'd0, prod};
      2'd3:    addend = {prod, 64'd0};
      default: addend = {32'd0, prod, 32'd0};
    endcase
    mlo = macc[63+FRAC_BITS:FRAC_BITS];
    mag = ((|macc[127:64+FRAC_BITS]) || mlo[63]) ? 64'(S64_MAX) : mlo;
    rem_sh = {rem, (divcnt == '0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      state        <= S_LOAD;
      phase        <= PH_COF;
      load_count   <= 4'd0;
      idx          <= 4'd0;
      opn          <= 4'd0;
      step         <= 2'd0;
      divcnt       <= '0;
      acc          <= 64'sd0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_APPLY && phase == PH_OUT) || state == S_SING;
      case (state)
        S_LOAD: begin
          if (do_accept) begin
            mat[load_count] <= elem_value;
            load_count      <= load_count + 4'd1;
            phase           <= PH_COF;
            idx             <= 4'd0;
            opn             <= 4'd0;
          end
        end
        S_FETCH_A: begin
          ma <= abs64(src_a);
          sa <= src_a[63];
        end
        S_FETCH_B: begin
          mb   <= abs64(src_b);
          sb   <= src_b[63];
          macc <= 128'd0;
          step <= 2'd0;
        end
        S_MUL: begin
          prod <= (step[1] ? ma[63:32] : ma[31:0]) * (step[0] ? mb[63:32] : mb[31:0]);
        end
        S_ACC: begin
          macc <= macc + addend;
          step <= step + 2'd1;
        end
        S_FIN: begin
          fres <= (sa ^ sb) ? 64'(-$signed(mag)) : $signed(mag);
        end
        S_APPLY: begin
          case (phase)
            PH_COF: begin
              if (cur_op.to_acc) begin
                acc <= (cur_op.mode == AM_LOAD) ? fres
                     : sat_addsub(acc, fres, cur_op.mode == AM_SUB);
              end else begin
                c_term <= (cur_op.mode == AM_LOAD) ? fres
                        : sat_addsub(c_term, fres, cur_op.mode == AM_SUB);
              end
              opn <= opn + 4'd1;
            end
            PH_DET: begin
              acc <= sat_addsub(acc, fres, 1'b0);
              idx <= idx + 4'd1;
            end
            default: begin
              out_value    <= sat32(fres);
              out_index    <= idx;
              singular     <= 1'b0;
              last         <= (idx == 4'd15);
              idx          <= idx + 4'd1;
            end
          endcase
        end
        S_STORE: begin
          // Cofactor sign follows the checkerboard; the store is transposed.
          adj[{idx[1:0], idx[3:2]}] <= (idx[2] ^ idx[0]) ? sat_addsub(64'sd0, acc, 1'b1)
                                                         : acc;
          opn <= 4'd0;
          idx <= idx + 4'd1;
          if (idx == 4'd15) begin
            phase <= PH_DET;
            acc   <= 64'sd0;
          end
        end
        S_DIVCHK: begin
          idx    <= 4'd0;
          dmag   <= abs64(acc);
          dneg   <= acc[63];
          rem    <= 64'd0;
          quo    <= '0;
          divcnt <= '0;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, dmag}) begin
            rem <= 64'(rem_sh - {1'b0, dmag});
            quo <= {quo[QW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[QW-2:0], 1'b0};
          end
          divcnt <= divcnt + 1'b1;
          if (divcnt == DIV_LAST) begin
            phase <= PH_OUT;
          end
        end
        S_SING: begin
          out_value    <= mat[idx];
          out_index    <= idx;
          singular     <= 1'b1;
          last         <= (idx == 4'd15);
          idx          <= idx + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // The reciprocal takes the sign of the determinant; it is settled once the
  // quotient shift register completes and is only read in the output phase.
  always_ff @(posedge clk) begin
    if (state == S_FETCH_A && phase == PH_OUT && idx == 4'd0) begin
      recip <= dneg ? 64'(-$signed({1'b0, quo})) : 64'($signed({1'b0, quo}));
    end
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid && !busy)
    else $error("result strobe continued after the last item");

  a_partial_load_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && load_count != 4'd15 |=> !busy && !result_valid)
    else $error("block left loading before the sixteenth element");

  a_results_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("result emitted outside a run");

  a_singular_steady: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid == 1'b0 || singular == $past(singular))
    else $error("singular flag changed within a run");

endmodule
